[hdl/ntca_pkg.sv]
// Package for the NTC ADC-to-temperature converter.
// Holds the table constants, derived widths and the segment info type.
// No dependencies.
package ntca_pkg;

  localparam int TABLE_POINTS = 19;
  localparam int ADC_BITS     = 12;
  localparam int TEMP_W       = 11;
  localparam int SEG_N        = TABLE_POINTS - 1;
  localparam int SEG_W        = (SEG_N > 1) ? $clog2(SEG_N) : 1;

  typedef logic [ADC_BITS-1:0]      adc_t;
  typedef logic signed [TEMP_W-1:0] temp_t;

  localparam temp_t TEMP_TAB [TABLE_POINTS] = '{
    -11'sd50, 11'sd0,   11'sd50,  11'sd100, 11'sd150, 11'sd200, 11'sd250,
    11'sd300, 11'sd350, 11'sd400, 11'sd450, 11'sd500, 11'sd550, 11'sd600,
    11'sd650, 11'sd700, 11'sd750, 11'sd800, 11'sd850
  };

  localparam adc_t CODES_SUPPLY [TABLE_POINTS] = '{
    12'd716, 12'd571, 12'd458, 12'd370, 12'd300, 12'd246, 12'd202,
    12'd167, 12'd139, 12'd117, 12'd98,  12'd83,  12'd71,  12'd60,
    12'd52,  12'd45,  12'd39,  12'd33,  12'd29
  };

  localparam adc_t CODES_SERIES [TABLE_POINTS] = '{
    12'd1765, 12'd1448, 12'd1180, 12'd958, 12'd777, 12'd630, 12'd511,
    12'd416,  12'd340,  12'd279,  12'd229, 12'd190, 12'd158, 12'd132,
    12'd110,  12'd93,   12'd78,   12'd67,  12'd57
  };

  // Temperature points are evenly spaced.
  localparam int TEMP_STEP = 50;
  localparam int STEP_W    = $clog2(TEMP_STEP + 1);
  localparam int Q_W       = STEP_W;
  localparam int PROD_W    = ADC_BITS + STEP_W;
  // Reciprocal scale: exact floor for dividends below 2**PROD_W and
  // divisors below 2**ADC_BITS.
  localparam int RECIP_K   = PROD_W + ADC_BITS;
  localparam int RECIP_W   = RECIP_K + 1;
  localparam int MUL_W     = PROD_W + RECIP_W;

  typedef struct packed {
    logic             hot;
    logic             cold;
    logic [SEG_W-1:0] seg;
  } seg_info_t;

endpackage

[hdl/ntc_adc_to_temperature.sv]
// Top level of the NTC ADC-to-temperature converter: four-stage pipeline of
// segment search, constant multiply, reciprocal multiply and final add.
// Depends on ntca_pkg and ntca_seg_search.
//
//   channel  direction  ports                                  role
//   in       sink       in_valid, in_ready, in_adc_code        one ADC code per beat
//   out      source     out_valid, out_ready, out_temperature_tenths
//   cfg      sink       cfg_valid, cfg_ready, cfg_data         table select
//
// One beat enters per cycle while in_ready is high; out_valid rises once the
// beat has passed through the four register stages in order: search, scale,
// reciprocal multiply and final add.
// Reset clears all stage valid bits and selects the supply table.
// A stall on out holds each full stage; empty stages still fill, so in_ready
// drops only once all four stages hold a beat.
module ntc_adc_to_temperature (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ntca_pkg::ADC_BITS-1:0] in_adc_code,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [ntca_pkg::TEMP_W-1:0] out_temperature_tenths,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data
);

  localparam int SN = ntca_pkg::SEG_N;

  // Per-segment constants.
  ntca_pkg::adc_t                   hi_sup    [SN];
  ntca_pkg::adc_t                   hi_ser    [SN];
  ntca_pkg::temp_t                  base_tab  [SN];
  logic [ntca_pkg::RECIP_W-1:0]     recip_sup [SN];
  logic [ntca_pkg::RECIP_W-1:0]     recip_ser [SN];

  for (genvar s = 0; s < SN; s++) begin : g_seg
    localparam longint DSUP = longint'(ntca_pkg::CODES_SUPPLY[s]) -
                              longint'(ntca_pkg::CODES_SUPPLY[s+1]);
    localparam longint DSER = longint'(ntca_pkg::CODES_SERIES[s]) -
                              longint'(ntca_pkg::CODES_SERIES[s+1]);
    localparam longint DSUP1 = (DSUP > 0) ? DSUP : 1;
    localparam longint DSER1 = (DSER > 0) ? DSER : 1;
    localparam longint MSUP = ((longint'(1) <<< ntca_pkg::RECIP_K) + DSUP1 - 1) / DSUP1;
    localparam longint MSER = ((longint'(1) <<< ntca_pkg::RECIP_K) + DSER1 - 1) / DSER1;
    assign hi_sup[s]    = ntca_pkg::CODES_SUPPLY[s];
    assign hi_ser[s]    = ntca_pkg::CODES_SERIES[s];
    assign base_tab[s]  = ntca_pkg::TEMP_TAB[s];
    assign recip_sup[s] = MSUP[ntca_pkg::RECIP_W-1:0];
    assign recip_ser[s] = MSER[ntca_pkg::RECIP_W-1:0];
  end

  logic sel_r;

  // Stage A: code, select and segment info.
  logic                a_valid_r, a_valid_nxt;
  ntca_pkg::adc_t      a_code_r;
  logic                a_sel_r;
  ntca_pkg::seg_info_t a_info_r, a_info_nxt;

  // Stage B: scaled numerator, reciprocal and base temperature.
  logic                         b_valid_r, b_valid_nxt;
  logic [ntca_pkg::PROD_W-1:0]  b_prod_r, b_prod_nxt;
  logic [ntca_pkg::RECIP_W-1:0] b_recip_r, b_recip_nxt;
  ntca_pkg::temp_t              b_base_r, b_base_nxt;
  logic                         b_hot_r, b_cold_r;

  // Stage C: quotient.
  logic                        c_valid_r, c_valid_nxt;
  logic [ntca_pkg::Q_W-1:0]    c_q_r, c_q_nxt;
  ntca_pkg::temp_t             c_base_r;
  logic                        c_hot_r, c_cold_r;

  // Output stage.
  logic                        out_valid_r, out_valid_nxt;
  ntca_pkg::temp_t             out_temp_r, out_temp_nxt;

  logic out_free, c_free, b_free, a_free;
  ntca_pkg::adc_t              b_num;
  logic [ntca_pkg::MUL_W-1:0]  c_full;

  assign out_free = !out_valid_r || out_ready;
  assign c_free   = !c_valid_r || out_free;
  assign b_free   = !b_valid_r || c_free;
  assign a_free   = !a_valid_r || b_free;

  assign in_ready               = a_free;
  assign cfg_ready              = 1'b1;
  assign out_valid              = out_valid_r;
  assign out_temperature_tenths = out_temp_r;

  ntca_seg_search u_seg_search (
    .code (in_adc_code),
    .sel  (sel_r),
    .info (a_info_nxt)
  );

  always_comb begin
    a_valid_nxt   = in_valid;
    b_valid_nxt   = a_valid_r;
    c_valid_nxt   = b_valid_r;
    out_valid_nxt = c_valid_r;

    b_num       = (a_sel_r ? hi_ser[a_info_r.seg] : hi_sup[a_info_r.seg]) - a_code_r;
    b_prod_nxt  = ntca_pkg::PROD_W'(b_num) * ntca_pkg::PROD_W'(ntca_pkg::TEMP_STEP);
    b_recip_nxt = a_sel_r ? recip_ser[a_info_r.seg] : recip_sup[a_info_r.seg];
    b_base_nxt  = base_tab[a_info_r.seg];

    c_full  = ntca_pkg::MUL_W'(b_prod_r) * ntca_pkg::MUL_W'(b_recip_r);
    c_q_nxt = c_full[ntca_pkg::RECIP_K +: ntca_pkg::Q_W];

    priority if (c_hot_r) begin
      out_temp_nxt = ntca_pkg::TEMP_TAB[ntca_pkg::TABLE_POINTS-1];
    end else if (c_cold_r) begin
      out_temp_nxt = ntca_pkg::TEMP_TAB[0];
    end else begin
      out_temp_nxt = c_base_r +
                     $signed({{(ntca_pkg::TEMP_W-ntca_pkg::Q_W){1'b0}}, c_q_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= 1'b0;
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sel_r <= cfg_data;
      end
      if (a_free) begin
        a_valid_r <= a_valid_nxt;
      end
      if (b_free) begin
        b_valid_r <= b_valid_nxt;
      end
      if (c_free) begin
        c_valid_r <= c_valid_nxt;
      end
      if (out_free) begin
        out_valid_r <= out_valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && in_valid) begin
      a_code_r <= in_adc_code;
      a_sel_r  <= sel_r;
      a_info_r <= a_info_nxt;
    end
    if (b_free && a_valid_r) begin
      b_prod_r  <= b_prod_nxt;
      b_recip_r <= b_recip_nxt;
      b_base_r  <= b_base_nxt;
      b_hot_r   <= a_info_r.hot;
      b_cold_r  <= a_info_r.cold;
    end
    if (c_free && b_valid_r) begin
      c_q_r    <= c_q_nxt;
      c_base_r <= b_base_r;
      c_hot_r  <= b_hot_r;
      c_cold_r <= b_cold_r;
    end
    if (out_free && c_valid_r) begin
      out_temp_r <= out_temp_nxt;
    end
  end

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_temp_r >= ntca_pkg::TEMP_TAB[0]) &&
                    (out_temp_r <= ntca_pkg::TEMP_TAB[ntca_pkg::TABLE_POINTS-1]))
    else $error("result outside the table temperature range");

  a_quot: assert property (@(posedge clk) disable iff (!rst_n)
    (c_valid_r && !c_hot_r && !c_cold_r) |->
      (int'(c_q_r) <= ntca_pkg::TEMP_STEP))
    else $error("interpolation quotient exceeds one temperature step");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (a_valid_r && b_valid_r && c_valid_r && out_valid_r))
    else $error("input stalled while a pipeline stage is empty");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !a_valid_r))
    else $error("valid bits not cleared by reset");

endmodule

[hdl/ntca_seg_search.sv]
// Segment search for the NTC converter: compares the code against every
// point of the selected table and finds the bracketing segment.
// Depends on ntca_pkg.
module ntca_seg_search (
  input  ntca_pkg::adc_t      code,
  input  logic                sel,
  output ntca_pkg::seg_info_t info
);

  ntca_pkg::adc_t tab [ntca_pkg::TABLE_POINTS];

  always_comb begin
    for (int i = 0; i < ntca_pkg::TABLE_POINTS; i++) begin
      tab[i] = sel ? ntca_pkg::CODES_SERIES[i] : ntca_pkg::CODES_SUPPLY[i];
    end
  end

  always_comb begin
    info.hot  = (code <= tab[ntca_pkg::TABLE_POINTS-1]);
    info.cold = (code >= tab[0]);
    info.seg  = '0;
    for (int i = 1; i < ntca_pkg::TABLE_POINTS - 1; i++) begin
      if (tab[i] > code) begin
        info.seg = ntca_pkg::SEG_W'(i);
      end
    end
  end

endmodule

[tb/sv/ntc_adc_to_temperature_tb.sv]
`timescale 1ns / 100ps
// Testbench for ntc_adc_to_temperature: a directed table, then random ADC codes,
// each checked against a table-interpolation predictor of the converter.
// Depends on ntca_pkg for the port types and on the converter RTL.
module ntc_adc_to_temperature_tb;

  localparam int N_POINTS       = 19;
  localparam int DIR_N          = 23;
  localparam int SEG_COUNT      = 9;
  localparam int SEG_ITEMS      = 47;
  localparam int HOLD_SEG       = 3;
  localparam int RX_HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES  = 8;
  localparam int IDLE_LIMIT     = 1000;

  localparam logic SEL_SUPPLY = 1'b0;
  localparam logic SEL_SERIES = 1'b1;

  typedef struct {
    logic            sel;
    ntca_pkg::adc_t  code;
    bit              typed;
    ntca_pkg::temp_t want;
  } dir_row_t;

  int point_tenths [N_POINTS] = '{
    -50, 0, 50, 100, 150, 200, 250, 300, 350, 400,
    450, 500, 550, 600, 650, 700, 750, 800, 850
  };
  int supply_codes [N_POINTS] = '{
    716, 571, 458, 370, 300, 246, 202, 167, 139, 117,
    98, 83, 71, 60, 52, 45, 39, 33, 29
  };
  int series_codes [N_POINTS] = '{
    1765, 1448, 1180, 958, 777, 630, 511, 416, 340, 279,
    229, 190, 158, 132, 110, 93, 78, 67, 57
  };

  dir_row_t dir_rows [DIR_N] = '{
    '{SEL_SUPPLY, 12'd0,    1'b1, 11'sd850},
    '{SEL_SUPPLY, 12'd4095, 1'b1, -11'sd50},
    '{SEL_SUPPLY, 12'd716,  1'b1, -11'sd50},
    '{SEL_SUPPLY, 12'd29,   1'b1, 11'sd850},
    '{SEL_SUPPLY, 12'd571,  1'b1, 11'sd0},
    '{SEL_SUPPLY, 12'd715,  1'b0, 11'sd0},
    '{SEL_SUPPLY, 12'd30,   1'b0, 11'sd0},
    '{SEL_SUPPLY, 12'd2730, 1'b1, -11'sd50},
    '{SEL_SUPPLY, 12'd1365, 1'b1, -11'sd50},
    '{SEL_SUPPLY, 12'd400,  1'b0, 11'sd0},
    '{SEL_SUPPLY, 12'd100,  1'b0, 11'sd0},
    '{SEL_SERIES, 12'd1765, 1'b1, -11'sd50},
    '{SEL_SERIES, 12'd1764, 1'b0, 11'sd0},
    '{SEL_SERIES, 12'd57,   1'b1, 11'sd850},
    '{SEL_SERIES, 12'd58,   1'b0, 11'sd0},
    '{SEL_SERIES, 12'd1448, 1'b1, 11'sd0},
    '{SEL_SERIES, 12'd1000, 1'b0, 11'sd0},
    '{SEL_SERIES, 12'd3000, 1'b1, -11'sd50},
    '{SEL_SERIES, 12'd0,    1'b1, 11'sd850},
    '{SEL_SERIES, 12'd4095, 1'b1, -11'sd50},
    '{SEL_SERIES, 12'd200,  1'b0, 11'sd0},
    '{SEL_SUPPLY, 12'd35,   1'b0, 11'sd0},
    '{SEL_SUPPLY, 12'd600,  1'b0, 11'sd0}
  };

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  ntca_pkg::adc_t  in_adc_code;
  logic            out_valid;
  logic            out_ready;
  ntca_pkg::temp_t out_temperature_tenths;
  logic            cfg_valid;
  logic            cfg_ready;
  logic            cfg_data;

  ntca_pkg::temp_t tenths_q [$];
  logic  table_sel;
  int    tx_idle_pct;
  int    rx_idle_pct;
  bit    rx_hold_req;
  int    mismatch_cnt;
  int    idle_cycles;

  ntc_adc_to_temperature dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_adc_code            (in_adc_code),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_temperature_tenths (out_temperature_tenths),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_data               (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int table_code(logic sel, int k);
    return (sel == SEL_SERIES) ? series_codes[k] : supply_codes[k];
  endfunction

  function automatic ntca_pkg::temp_t predict_tenths(ntca_pkg::adc_t code, logic sel);
    int hi;
    int lo;
    int seg;
    int t;
    if (int'(code) <= table_code(sel, N_POINTS - 1))
      return ntca_pkg::temp_t'(point_tenths[N_POINTS - 1]);
    if (int'(code) >= table_code(sel, 0))
      return ntca_pkg::temp_t'(point_tenths[0]);
    seg = 0;
    for (int k = 1; k + 1 < N_POINTS; k++) begin
      if (table_code(sel, k) > int'(code)) seg = k;
    end
    hi = table_code(sel, seg);
    lo = table_code(sel, seg + 1);
    t = point_tenths[seg] +
        ((hi - int'(code)) * (point_tenths[seg + 1] - point_tenths[seg])) / (hi - lo);
    return ntca_pkg::temp_t'(t);
  endfunction

  // Most codes land inside the table span, some next to a table point, the rest anywhere.
  function automatic ntca_pkg::adc_t random_code(logic sel);
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 60) begin
      v = $urandom_range(table_code(sel, 0), table_code(sel, N_POINTS - 1));
    end else if (r < 80) begin
      v = table_code(sel, $urandom_range(N_POINTS - 1)) + $urandom_range(4) - 2;
    end else begin
      v = $urandom_range(4095);
    end
    return ntca_pkg::adc_t'(v);
  endfunction

  task automatic send_code(input ntca_pkg::adc_t code, input ntca_pkg::temp_t want);
    in_valid <= 1'b1;
    in_adc_code <= code;
    do @(posedge clk); while (!in_ready);
    tenths_q.push_back(want);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(18, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (tenths_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_table_sel(input logic sel);
    cfg_valid <= 1'b1;
    cfg_data <= sel;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    table_sel = sel;
  endtask

  initial begin : rx_pace
    int stall;
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if ($urandom_range(99) < rx_idle_pct) begin
        stall = $urandom_range(18, 1);
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_out
    ntca_pkg::temp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tenths_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result beat, expected none actual %0d", $time,
                 out_temperature_tenths);
      end else begin
        want = tenths_q.pop_front();
        if (out_temperature_tenths !== want) begin
          mismatch_cnt++;
          $display("%0t: temperature_tenths expected %0d actual %0d", $time, want,
                   out_temperature_tenths);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : main_seq
    ntca_pkg::adc_t code;
    ntca_pkg::temp_t want;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_adc_code <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= 1'b0;
    table_sel = SEL_SUPPLY;
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    rx_hold_req = 1'b0;
    mismatch_cnt = 0;
    idle_cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_N; r++) begin
      if (dir_rows[r].sel != table_sel) begin
        wait_results_done();
        write_table_sel(dir_rows[r].sel);
      end
      want = dir_rows[r].typed ? dir_rows[r].want : predict_tenths(dir_rows[r].code, table_sel);
      send_code(dir_rows[r].code, want);
    end

    for (int s = 0; s < SEG_COUNT; s++) begin
      // The sender waits here until every outstanding beat has been returned.
      wait_results_done();
      write_table_sel(logic'($urandom_range(1)));
      tx_idle_pct = (s == SEG_COUNT - 1) ? 0 : 10 * $urandom_range(3);
      rx_idle_pct = (s == SEG_COUNT - 1) ? 0 : 10 * $urandom_range(3);
      if (s == HOLD_SEG) begin
        tx_idle_pct = 0;
        rx_hold_req = 1'b1;
      end
      for (int i = 0; i < SEG_ITEMS; i++) begin
        code = random_code(table_sel);
        send_code(code, predict_tenths(code, table_sel));
      end
    end

    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/ntca_pkg.sv
hdl/ntca_seg_search.sv
hdl/ntc_adc_to_temperature.sv
tb/sv/ntc_adc_to_temperature_tb.sv
